FILE: hw/rtl/cnr3_pkg.sv
// cnr3_pkg: shared types, constants and the reference colour table for the
// nearest reference colour (top three) classifier.
// No dependencies.
package cnr3_pkg;

  // Field widths fixed by the word layout
  localparam int unsigned ReadingW = 12;
  localparam int unsigned IndexW   = 4;
  localparam int unsigned PctW     = 15;

  // Default parameter values for the top level
  localparam int unsigned SampleBitsDefault = 12;
  localparam int unsigned RefCountDefault   = 12;
  localparam int unsigned TableSize         = 12;

  // Internal arithmetic widths
  localparam int unsigned TotalW    = ReadingW + 2;      // sum of three readings
  localparam int unsigned DividendW = ReadingW + PctW;   // corrected * 25600
  localparam int unsigned DistW     = 32;                // sum of three squares
  localparam int unsigned RefPctW   = 7;                 // table entries, percent

  localparam logic [PctW-1:0] PctScale = PctW'(25600);   // 100 percent in Q7.8

  // Command codes
  localparam logic CmdMeasure = 1'b0;
  localparam logic CmdReset   = 1'b1;

  // Colour component select
  localparam logic [1:0] CompRed   = 2'd0;
  localparam logic [1:0] CompGreen = 2'd1;
  localparam logic [1:0] CompBlue  = 2'd2;

  typedef struct packed {
    logic                command;
    logic [ReadingW-1:0] red_reading;
    logic [ReadingW-1:0] green_reading;
    logic [ReadingW-1:0] blue_reading;
  } in_word_t;

  typedef struct packed {
    logic [IndexW-1:0]   nearest_first;
    logic [IndexW-1:0]   nearest_second;
    logic [IndexW-1:0]   nearest_third;
    logic [ReadingW-1:0] red_corrected;
    logic [ReadingW-1:0] green_corrected;
    logic [ReadingW-1:0] blue_corrected;
    logic [PctW-1:0]     red_percent;
    logic [PctW-1:0]     green_percent;
    logic [PctW-1:0]     blue_percent;
  } out_word_t;

  // Reference colours in whole percent: red, green, blue, yellow, cyan,
  // magenta, orange, pink, purple, white, gray, black.
  function automatic logic [RefPctW-1:0] ref_pct(input logic [IndexW-1:0] idx,
                                                 input logic [1:0]        comp);
    logic [3*RefPctW-1:0] rgb;
    unique case (idx)
      4'd0:    rgb = {7'd100, 7'd0,   7'd0};
      4'd1:    rgb = {7'd0,   7'd100, 7'd0};
      4'd2:    rgb = {7'd0,   7'd0,   7'd100};
      4'd3:    rgb = {7'd50,  7'd50,  7'd0};
      4'd4:    rgb = {7'd0,   7'd50,  7'd50};
      4'd5:    rgb = {7'd50,  7'd0,   7'd50};
      4'd6:    rgb = {7'd70,  7'd30,  7'd0};
      4'd7:    rgb = {7'd70,  7'd20,  7'd10};
      4'd8:    rgb = {7'd40,  7'd0,   7'd60};
      4'd9:    rgb = {7'd33,  7'd33,  7'd33};
      4'd10:   rgb = {7'd33,  7'd33,  7'd33};
      default: rgb = {7'd0,   7'd0,   7'd0};
    endcase
    unique case (comp)
      CompRed:   ref_pct = rgb[3*RefPctW-1:2*RefPctW];
      CompGreen: ref_pct = rgb[2*RefPctW-1:RefPctW];
      default:   ref_pct = rgb[RefPctW-1:0];
    endcase
  endfunction

endpackage

FILE: hw/rtl/color_nearest_reference_top3_top.sv
// Measure words are taken one at a time: the input stalls from acceptance
//   until the result word is handed on; reset and calibrate finish in IDLE.
// Each share goes through the shared restoring divider, and each reference
//   through the shared squarer, one component at a time.
// Reset (rst_ni, async, active low): uncalibrated, background zero, no result.
// Depends on cnr3_pkg.
module color_nearest_reference_top3_top #(
  parameter int unsigned SAMPLE_BITS = cnr3_pkg::SampleBitsDefault,  // 8..16
  parameter int unsigned REF_COUNT   = cnr3_pkg::RefCountDefault     // 3..12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cnr3_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cnr3_pkg::out_word_t out_data_o
);

  localparam int unsigned RW = cnr3_pkg::ReadingW;
  localparam int unsigned PW = cnr3_pkg::PctW;
  localparam int unsigned TW = cnr3_pkg::TotalW;
  localparam int unsigned DW = cnr3_pkg::DistW;
  localparam int unsigned IW = cnr3_pkg::IndexW;

  // Readings are taken modulo 2^SAMPLE_BITS; wider samples leave the 12-bit
  // field untouched.
  localparam logic [RW-1:0] SampleMask =
    (SAMPLE_BITS >= RW) ? {RW{1'b1}} : RW'((32'd1 << SAMPLE_BITS) - 32'd1);
  localparam logic [IW-1:0] LastRef  = IW'(REF_COUNT - 1);
  localparam logic [3:0]    LastStep = 4'(PW - 1);
  localparam logic [DW-1:0] DistMax  = {DW{1'b1}};

  // Sequencer
  //   IDLE : take a word; reset and calibrate finish here
  //   PREP : sum of the corrected readings
  //   DLOAD: load corrected * 25600 for the next share
  //   DIV  : one quotient bit a cycle
  //   DIST : one squared component difference a cycle
  //   RANK : insert the finished distance into the top three
  //   EMIT : hand the result to the output register once it is free
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PREP  = 7'b0000010,
    ST_DLOAD = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_DIST  = 7'b0010000,
    ST_RANK  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic          cal_q, cal_d;
  logic [RW-1:0] bg_q [3];
  logic [RW-1:0] bg_d [3];

  logic [RW-1:0] corr_q [3];
  logic [RW-1:0] corr_d [3];
  logic [PW-1:0] pct_q  [3];
  logic [PW-1:0] pct_d  [3];
  logic [TW-1:0] total_q, total_d;

  logic [1:0]    comp_q, comp_d;      // share or component in progress
  logic [3:0]    step_q, step_d;      // divider step
  logic [TW-1:0] rem_q, rem_d;        // partial remainder
  logic [PW-1:0] quo_q, quo_d;        // dividend low bits out, quotient bits in

  logic [IW-1:0] ref_q, ref_d;
  logic [DW-1:0] acc_q, acc_d;
  logic [DW-1:0] best_d_q [3];
  logic [DW-1:0] best_d_d [3];
  logic [IW-1:0] best_i_q [3];
  logic [IW-1:0] best_i_d [3];

  logic                out_valid_q, out_valid_d;
  cnr3_pkg::out_word_t out_q, out_d;

  logic                      in_fire;
  logic [RW-1:0]             rd [3];
  logic [cnr3_pkg::DividendW-1:0] dividend;
  logic [TW:0]               trial;
  logic                      trial_ge;
  logic [PW-1:0]             target;
  logic [PW-1:0]             diff;
  logic [2*PW-1:0]           sq;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign rd[0] = in_data_i.red_reading   & SampleMask;
  assign rd[1] = in_data_i.green_reading & SampleMask;
  assign rd[2] = in_data_i.blue_reading  & SampleMask;

  // Divider datapath: restoring, quotient known to fit in PW bits
  assign dividend = cnr3_pkg::DividendW'(corr_q[comp_q]) *
                    cnr3_pkg::DividendW'(cnr3_pkg::PctScale);
  assign trial    = {rem_q, quo_q[PW-1]};
  assign trial_ge = (trial >= {1'b0, total_q});

  // Distance datapath: the one squarer, fed a component at a time
  assign target = {cnr3_pkg::ref_pct(ref_q, comp_q), 8'd0};
  assign diff   = (pct_q[comp_q] > target) ? (pct_q[comp_q] - target)
                                           : (target - pct_q[comp_q]);
  assign sq     = diff * diff;

  always_comb begin
    state_d     = state_q;
    cal_d       = cal_q;
    bg_d        = bg_q;
    corr_d      = corr_q;
    pct_d       = pct_q;
    total_d     = total_q;
    comp_d      = comp_q;
    step_d      = step_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    ref_d       = ref_q;
    acc_d       = acc_q;
    best_d_d    = best_d_q;
    best_i_d    = best_i_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          priority if (in_data_i.command == cnr3_pkg::CmdReset) begin
            cal_d = 1'b0;
          end else if (!cal_q) begin
            bg_d  = rd;
            cal_d = 1'b1;
          end else begin
            for (int c = 0; c < 3; c++) begin
              corr_d[c] = (rd[c] > bg_q[c]) ? (rd[c] - bg_q[c]) : '0;
            end
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        total_d = TW'(corr_q[0]) + TW'(corr_q[1]) + TW'(corr_q[2]);
        if (total_d == '0) begin
          total_d = TW'(1);  // empty reading: all shares come out zero
        end
        comp_d  = cnr3_pkg::CompRed;
        state_d = ST_DLOAD;
      end
      ST_DLOAD: begin
        rem_d   = TW'(dividend[cnr3_pkg::DividendW-1:PW]);
        quo_d   = dividend[PW-1:0];
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d  = trial_ge ? TW'(trial - {1'b0, total_q}) : trial[TW-1:0];
        quo_d  = {quo_q[PW-2:0], trial_ge};
        step_d = step_q + 4'd1;
        if (step_q == LastStep) begin
          pct_d[comp_q] = quo_d;
          if (comp_q == cnr3_pkg::CompBlue) begin
            comp_d   = cnr3_pkg::CompRed;
            ref_d    = '0;
            best_d_d = '{DistMax, DistMax, DistMax};
            best_i_d = '{'0, '0, '0};
            state_d  = ST_DIST;
          end else begin
            comp_d  = comp_q + 2'd1;
            state_d = ST_DLOAD;
          end
        end
      end
      ST_DIST: begin
        acc_d = ((comp_q == cnr3_pkg::CompRed) ? '0 : acc_q) + DW'(sq);
        if (comp_q == cnr3_pkg::CompBlue) begin
          comp_d  = cnr3_pkg::CompRed;
          state_d = ST_RANK;
        end else begin
          comp_d = comp_q + 2'd1;
        end
      end
      ST_RANK: begin
        // strict compares keep the lower index ahead on a tie
        priority if (acc_q < best_d_q[0]) begin
          best_d_d = '{acc_q, best_d_q[0], best_d_q[1]};
          best_i_d = '{ref_q, best_i_q[0], best_i_q[1]};
        end else if (acc_q < best_d_q[1]) begin
          best_d_d[2] = best_d_q[1];
          best_i_d[2] = best_i_q[1];
          best_d_d[1] = acc_q;
          best_i_d[1] = ref_q;
        end else if (acc_q < best_d_q[2]) begin
          best_d_d[2] = acc_q;
          best_i_d[2] = ref_q;
        end else begin
          best_d_d = best_d_q;
        end
        if (ref_q == LastRef) begin
          state_d = ST_EMIT;
        end else begin
          ref_d   = ref_q + IW'(1);
          state_d = ST_DIST;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d           = 1'b1;
          out_d.nearest_first   = best_i_q[0];
          out_d.nearest_second  = best_i_q[1];
          out_d.nearest_third   = best_i_q[2];
          out_d.red_corrected   = corr_q[0];
          out_d.green_corrected = corr_q[1];
          out_d.blue_corrected  = corr_q[2];
          out_d.red_percent     = pct_q[0];
          out_d.green_percent   = pct_q[1];
          out_d.blue_percent    = pct_q[2];
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and the stored background
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cal_q       <= 1'b0;
      bg_q        <= '{'0, '0, '0};
      out_valid_q <= 1'b0;
      comp_q      <= '0;
      step_q      <= '0;
      ref_q       <= '0;
    end else begin
      state_q     <= state_d;
      cal_q       <= cal_d;
      bg_q        <= bg_d;
      out_valid_q <= out_valid_d;
      comp_q      <= comp_d;
      step_q      <= step_d;
      ref_q       <= ref_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    corr_q   <= corr_d;
    pct_q    <= pct_d;
    total_q  <= total_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    acc_q    <= acc_d;
    best_d_q <= best_d_d;
    best_i_q <= best_i_d;
    out_q    <= out_d;
  end

  // Divider remainder stays below a non-zero divisor throughout
  a_div_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> total_q != '0 && rem_q < total_q)
    else $error("divider remainder out of range");

  // Top three kept in distance order while ranking
  a_rank_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RANK || state_q == ST_EMIT) |->
      best_d_q[0] <= best_d_q[1] && best_d_q[1] <= best_d_q[2])
    else $error("top three out of order");

  // A result word appears only from the emit step
  a_emit_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result word without emit");

  // Three distinct colours reported
  a_distinct : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.nearest_first != out_q.nearest_second &&
                    out_q.nearest_second != out_q.nearest_third &&
                    out_q.nearest_first != out_q.nearest_third)
    else $error("repeated colour index");

endmodule

FILE: tb/colour_match_checker.sv
// colour_match_checker: watches both word channels of the top-three colour
// classifier, predicts each result word and compares it field by field.
// Depends on cnr3_pkg.
module colour_match_checker #(
  parameter int unsigned RefCount = cnr3_pkg::RefCountDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  cnr3_pkg::in_word_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  cnr3_pkg::out_word_t out_data_i,
  output logic [31:0]         words_owed_o,
  output logic [31:0]         mismatch_count_o
);

  localparam int unsigned ShareScale = 25600;  // 100 percent in Q7.8

  cnr3_pkg::out_word_t owed_words[$];
  int unsigned         mismatches = 0;
  logic [11:0]         bg_red, bg_green, bg_blue;
  logic                calibrated;

  assign mismatch_count_o = mismatches;

  // reference colours, whole percent {red, green, blue}
  function automatic logic [20:0] palette(input int unsigned idx);
    case (idx)
      0:       palette = {7'd100, 7'd0,   7'd0};
      1:       palette = {7'd0,   7'd100, 7'd0};
      2:       palette = {7'd0,   7'd0,   7'd100};
      3:       palette = {7'd50,  7'd50,  7'd0};
      4:       palette = {7'd0,   7'd50,  7'd50};
      5:       palette = {7'd50,  7'd0,   7'd50};
      6:       palette = {7'd70,  7'd30,  7'd0};
      7:       palette = {7'd70,  7'd20,  7'd10};
      8:       palette = {7'd40,  7'd0,   7'd60};
      9:       palette = {7'd33,  7'd33,  7'd33};
      10:      palette = {7'd33,  7'd33,  7'd33};
      default: palette = {7'd0,   7'd0,   7'd0};
    endcase
  endfunction

  function automatic longint unsigned sq_gap(input int unsigned a, input int unsigned b);
    longint unsigned d;
    d = (a > b) ? longint'(a - b) : longint'(b - a);
    return d * d;
  endfunction

  function automatic int unsigned floored(input logic [11:0] v, input logic [11:0] bg);
    return (v > bg) ? int'(v - bg) : 0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // state update, plus the expected word for a calibrated measure
  task automatic classify_word(input cnr3_pkg::in_word_t w);
    cnr3_pkg::out_word_t res;
    int unsigned         cr, cg, cb, total, pr, pg, pb, filled;
    logic [20:0]         rgb;
    longint unsigned     d;
    longint unsigned     best_d[3];
    int unsigned         best_i[3];
    if (w.command == cnr3_pkg::CmdReset) begin
      calibrated = 1'b0;
      return;
    end
    if (!calibrated) begin
      bg_red     = w.red_reading;
      bg_green   = w.green_reading;
      bg_blue    = w.blue_reading;
      calibrated = 1'b1;
      return;
    end
    cr = floored(w.red_reading, bg_red);
    cg = floored(w.green_reading, bg_green);
    cb = floored(w.blue_reading, bg_blue);
    total = cr + cg + cb;
    if (total == 0) total = 1;
    pr = (cr * ShareScale) / total;
    pg = (cg * ShareScale) / total;
    pb = (cb * ShareScale) / total;

    filled = 0;
    for (int k = 0; k < 3; k++) begin
      best_d[k] = 0;
      best_i[k] = 0;
    end
    // running top three, strict less-than keeps the lower index on a tie
    for (int i = 0; i < RefCount && i < cnr3_pkg::TableSize; i++) begin
      rgb = palette(i);
      d = sq_gap(pr, 32'(rgb[20:14]) << 8) + sq_gap(pg, 32'(rgb[13:7]) << 8)
        + sq_gap(pb, 32'(rgb[6:0]) << 8);
      if (filled < 1 || d < best_d[0]) begin
        best_d[2] = best_d[1]; best_i[2] = best_i[1];
        best_d[1] = best_d[0]; best_i[1] = best_i[0];
        best_d[0] = d;         best_i[0] = i;
      end else if (filled < 2 || d < best_d[1]) begin
        best_d[2] = best_d[1]; best_i[2] = best_i[1];
        best_d[1] = d;         best_i[1] = i;
      end else if (filled < 3 || d < best_d[2]) begin
        best_d[2] = d;         best_i[2] = i;
      end
      if (filled < 3) filled++;
    end

    res.nearest_first   = 4'(best_i[0]);
    res.nearest_second  = 4'(best_i[1]);
    res.nearest_third   = 4'(best_i[2]);
    res.red_corrected   = 12'(cr);
    res.green_corrected = 12'(cg);
    res.blue_corrected  = 12'(cb);
    res.red_percent     = 15'(pr);
    res.green_percent   = 15'(pg);
    res.blue_percent    = 15'(pb);
    owed_words.push_back(res);
  endtask

  task automatic check_word(input cnr3_pkg::out_word_t got);
    cnr3_pkg::out_word_t want;
    if (owed_words.size() == 0) begin
      report_mismatch($sformatf("result word %h arrived with none owed", got));
      return;
    end
    want = owed_words.pop_front();
    if (got.nearest_first !== want.nearest_first)
      report_mismatch($sformatf("nearest_first %0d, expected %0d",
                                got.nearest_first, want.nearest_first));
    if (got.nearest_second !== want.nearest_second)
      report_mismatch($sformatf("nearest_second %0d, expected %0d",
                                got.nearest_second, want.nearest_second));
    if (got.nearest_third !== want.nearest_third)
      report_mismatch($sformatf("nearest_third %0d, expected %0d",
                                got.nearest_third, want.nearest_third));
    if (got.red_corrected !== want.red_corrected)
      report_mismatch($sformatf("red_corrected %0d, expected %0d",
                                got.red_corrected, want.red_corrected));
    if (got.green_corrected !== want.green_corrected)
      report_mismatch($sformatf("green_corrected %0d, expected %0d",
                                got.green_corrected, want.green_corrected));
    if (got.blue_corrected !== want.blue_corrected)
      report_mismatch($sformatf("blue_corrected %0d, expected %0d",
                                got.blue_corrected, want.blue_corrected));
    if (got.red_percent !== want.red_percent)
      report_mismatch($sformatf("red_percent %0d, expected %0d",
                                got.red_percent, want.red_percent));
    if (got.green_percent !== want.green_percent)
      report_mismatch($sformatf("green_percent %0d, expected %0d",
                                got.green_percent, want.green_percent));
    if (got.blue_percent !== want.blue_percent)
      report_mismatch($sformatf("blue_percent %0d, expected %0d",
                                got.blue_percent, want.blue_percent));
  endtask

  // result side first: a word accepted now can never answer one accepted now
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      bg_red     = '0;
      bg_green   = '0;
      bg_blue    = '0;
      calibrated = 1'b0;
      owed_words.delete();
      words_owed_o <= '0;
    end else begin
      if (out_valid_i && !out_stall_i) check_word(out_data_i);
      if (in_valid_i && !in_stall_i) classify_word(in_data_i);
      words_owed_o <= owed_words.size();
    end
  end

endmodule

FILE: tb/tb_color_nearest_reference_top3_top.sv
// tb_color_nearest_reference_top3_top: stimulus and verdict for the top-three
// colour classifier; checking lives in colour_match_checker.
// Depends on cnr3_pkg, color_nearest_reference_top3_top, colour_match_checker.
module tb_color_nearest_reference_top3_top;

  // Receiver stall behaviour, picked afresh for each run of cycles
  typedef enum int unsigned {
    StallNone, StallLight, StallHeavy, StallToggle
  } stall_mode_e;

  // How a random measure word is shaped around the stored background
  typedef enum int unsigned {
    ShapeNearRef, ShapeAnyValue, ShapeBelowBackground, ShapeExtremes, ShapeFaint
  } shape_e;

  localparam int unsigned RandomWords = 500;     // total words sent, roughly
  localparam int unsigned HoldCycles  = 600;     // one long receiver hold-off
  localparam int unsigned SettleCycles = 150;    // margin after the final drain

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  cnr3_pkg::in_word_t  in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  cnr3_pkg::out_word_t out_data_o;

  logic [31:0] words_owed;
  logic [31:0] mismatch_count;

  logic        hold_req;         // raised by the sender, served by the receiver
  int unsigned words_sent;
  int unsigned burst_left;
  int unsigned gap_max;
  logic [11:0] bg_r, bg_g, bg_b; // background the stimulus believes is stored
  int unsigned session_len;
  int unsigned bg_pick;
  bit          hold_done, drain_done;
  stall_mode_e stall_mode;
  int unsigned stall_run;

  color_nearest_reference_top3_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  colour_match_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_data_i       (out_data_o),
    .words_owed_o     (words_owed),
    .mismatch_count_o (mismatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Single reset at the start; every input known from time zero
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    hold_req    = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [11:0] clip(input int unsigned v);
    return (v > 4095) ? 12'd4095 : 12'(v);
  endfunction

  // floor, ceiling or exactly the background for one channel
  function automatic logic [11:0] extreme_of(input logic [11:0] bg);
    case ($urandom_range(0, 2))
      0:       return 12'd0;
      1:       return 12'd4095;
      default: return bg;
    endcase
  endfunction

  // Offer one word and hold it until taken. Bursts of random length; a gap
  // (valid low) may open before a burst. Valid stays high across a burst so
  // it is never dropped and raised within one step.
  task automatic send_word(input cnr3_pkg::in_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_data_i  <= w;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_measure(input logic [11:0] r, input logic [11:0] g,
                              input logic [11:0] b);
    cnr3_pkg::in_word_t w;
    w.command       = cnr3_pkg::CmdMeasure;
    w.red_reading   = r;
    w.green_reading = g;
    w.blue_reading  = b;
    send_word(w);
  endtask

  // clear calibration; readings ride along and must be ignored
  task automatic send_reset(input logic [11:0] r, input logic [11:0] g,
                            input logic [11:0] b);
    cnr3_pkg::in_word_t w;
    w.command       = cnr3_pkg::CmdReset;
    w.red_reading   = r;
    w.green_reading = g;
    w.blue_reading  = b;
    send_word(w);
  endtask

  // measure while uncalibrated: readings become the background
  task automatic calibrate(input logic [11:0] r, input logic [11:0] g,
                           input logic [11:0] b);
    bg_r = r;
    bg_g = g;
    bg_b = b;
    send_measure(r, g, b);
  endtask

  // Sender pause: valid low until every owed result word has been taken.
  // The owed count is registered in the checker, hence the do-while.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (words_owed != 0);
  endtask

  // A measure word with random content; mostly aimed near a reference colour
  // so every index shows up in the ranking, the rest probes floors and noise.
  task automatic shaped_measure();
    int unsigned pick, idx, span;
    shape_e      shape;
    pick  = $urandom_range(0, 9);
    shape = (pick < 6) ? ShapeNearRef : shape_e'(pick - 5);
    case (shape)
      ShapeNearRef: begin
        idx  = $urandom_range(0, 11);
        span = $urandom_range(0, 3000);
        send_measure(
          clip(bg_r + cnr3_pkg::ref_pct(4'(idx), cnr3_pkg::CompRed) * span / 100
               + $urandom_range(0, 30)),
          clip(bg_g + cnr3_pkg::ref_pct(4'(idx), cnr3_pkg::CompGreen) * span / 100
               + $urandom_range(0, 30)),
          clip(bg_b + cnr3_pkg::ref_pct(4'(idx), cnr3_pkg::CompBlue) * span / 100
               + $urandom_range(0, 30)));
      end
      ShapeAnyValue:
        send_measure(12'($urandom), 12'($urandom), 12'($urandom));
      ShapeBelowBackground:
        send_measure(12'($urandom_range(0, bg_r)), 12'($urandom_range(0, bg_g)),
                     12'($urandom_range(0, bg_b)));
      ShapeExtremes:
        send_measure(extreme_of(bg_r), extreme_of(bg_g), extreme_of(bg_b));
      default:
        send_measure(clip(bg_r + $urandom_range(0, 8)), clip(bg_g + $urandom_range(0, 8)),
                     clip(bg_b + $urandom_range(0, 8)));
    endcase
  endtask

  // Receiver: stall pattern of its own in runs of random length. A hold
  // request from the sender freezes out_stall_i high for HoldCycles, counted
  // here, so the block backs up while the sender keeps offering words.
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_run  = $urandom_range(16, 160);
      repeat (stall_run) begin
        @(posedge clk_i);
        if (hold_req) begin
          out_stall_i <= 1'b1;
          repeat (HoldCycles) @(posedge clk_i);
          hold_req <= 1'b0;
        end
        case (stall_mode)
          StallNone:  out_stall_i <= 1'b0;
          StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
          StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:    out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  // Sender: directed words, then random sessions, then the verdict
  initial begin
    words_sent = 0;
    burst_left = 0;
    gap_max    = 4;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    bg_r = '0;
    bg_g = '0;
    bg_b = '0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // zero background, then pure and mixed colours
    calibrate(12'd0, 12'd0, 12'd0);
    send_measure(12'd0, 12'd0, 12'd0);           // zero total, shares all zero
    send_measure(12'd4095, 12'd0, 12'd0);
    send_measure(12'd0, 12'd4095, 12'd0);
    send_measure(12'd0, 12'd0, 12'd4095);
    send_measure(12'd4095, 12'd4095, 12'd4095);  // white and gray tie
    send_measure(12'd2000, 12'd2000, 12'd0);
    send_measure(12'd0, 12'd2000, 12'd2000);
    send_measure(12'd2000, 12'd0, 12'd2000);
    send_measure(12'd2800, 12'd1200, 12'd0);
    send_measure(12'd2800, 12'd800, 12'd400);
    send_measure(12'd1600, 12'd0, 12'd2400);
    send_measure(12'd1, 12'd0, 12'd0);
    // reset with full readings, then a second reset while uncalibrated
    send_reset(12'd4095, 12'd4095, 12'd4095);
    send_reset(12'd0, 12'd0, 12'd0);
    // full-scale background: everything floors to zero
    calibrate(12'd4095, 12'd4095, 12'd4095);
    send_measure(12'd4095, 12'd4095, 12'd4095);
    send_measure(12'd0, 12'd123, 12'd4095);
    // mixed background: one channel floors, the others do not
    send_reset(12'd0, 12'd0, 12'd0);
    calibrate(12'd1000, 12'd2000, 12'd3000);
    send_measure(12'd1500, 12'd1000, 12'd3500);
    send_measure(12'd4095, 12'd4095, 12'd4095);
    wait_for_results();

    // Random sessions: reset, calibrate, a run of measures. Now and then a
    // fully random word as noise, which may itself reset or recalibrate.
    while (words_sent < RandomWords) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      send_reset(12'($urandom), 12'($urandom), 12'($urandom));
      bg_pick = $urandom_range(0, 7);
      if (bg_pick == 0)
        calibrate(12'd0, 12'd0, 12'd0);
      else if (bg_pick <= 4)
        calibrate(12'($urandom_range(0, 300)), 12'($urandom_range(0, 300)),
                  12'($urandom_range(0, 300)));
      else if (bg_pick <= 6)
        calibrate(12'($urandom), 12'($urandom), 12'($urandom));
      else
        calibrate(12'd4095, 12'd4095, 12'd4095);
      session_len = $urandom_range(4, 40);
      repeat (session_len) begin
        if ($urandom_range(0, 24) == 0)
          send_word(cnr3_pkg::in_word_t'({$urandom, $urandom}));
        else
          shaped_measure();
        // long receiver hold-off while words keep coming
        if (!hold_done && words_sent >= 150) begin
          hold_req <= 1'b1;
          hold_done = 1'b1;
        end
        // one full drain mid-run
        if (!drain_done && words_sent >= 330) begin
          wait_for_results();
          drain_done = 1'b1;
        end
      end
    end

    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && words_owed == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: color_nearest_reference_top3_top.f
hw/rtl/cnr3_pkg.sv
hw/rtl/color_nearest_reference_top3_top.sv
tb/colour_match_checker.sv
tb/tb_color_nearest_reference_top3_top.sv
